### hw/rtl/bss_pkg.sv
package bss_pkg;

  localparam logic [1:0] ACT_PUSH = 2'd0;
  localparam logic [1:0] ACT_POP  = 2'd1;
  localparam logic [1:0] ACT_FIND = 2'd2;

  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_FULL  = 2'd1;
  localparam logic [1:0] ST_EMPTY = 2'd2;

  localparam logic signed [31:0] NOT_FOUND = -32'sd1;

  typedef struct packed {
    logic [1:0]         action;
    logic signed [31:0] value;
  } cmd_t;

  typedef struct packed {
    logic [1:0]         status;
    logic signed [31:0] result_value;
    logic [6:0]         fill_level;
  } res_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_POP,
    S_SCAN,
    S_FINISH
  } state_t;

  // status seen by the sequencer
  typedef struct packed {
    logic       cmd_valid;
    logic [1:0] action;
    logic       empty;
    logic       scan_hit;
    logic       scan_end;
    logic       slot_free;
  } seq_stat_t;

  // strobes from the sequencer to the datapath
  typedef struct packed {
    logic cmd_ready;
    logic accept;
    logic pop_capture;
    logic scan;
    logic out_load;
  } seq_ctrl_t;

endpackage

### hw/rtl/bss_mem.sv
module bss_mem import bss_pkg::*; #(
  parameter int DEPTH = 64,
  parameter int AW    = 6
) (
  input  logic              clk,
  input  logic              we,
  input  logic [AW-1:0]     waddr,
  input  logic [31:0]       wdata,
  input  logic [AW-1:0]     raddr,
  output logic [31:0]       rdata
);

  logic [31:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

### hw/rtl/bss_seq.sv
module bss_seq import bss_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  seq_stat_t stat,
  output seq_ctrl_t ctrl
);

  state_t state;
  state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (stat.cmd_valid) begin
          priority if (stat.action == ACT_POP && !stat.empty) begin
            state_next = S_POP;
          end else if (stat.action == ACT_FIND) begin
            state_next = S_SCAN;
          end else begin
            state_next = S_FINISH;
          end
        end
      end
      S_POP: begin
        state_next = S_FINISH;
      end
      S_SCAN: begin
        if (stat.scan_hit || stat.scan_end) begin
          state_next = S_FINISH;
        end
      end
      S_FINISH: begin
        if (stat.slot_free) begin
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_comb begin
    ctrl.cmd_ready   = (state == S_IDLE);
    ctrl.accept      = (state == S_IDLE) && stat.cmd_valid;
    ctrl.pop_capture = (state == S_POP);
    ctrl.scan        = (state == S_SCAN);
    ctrl.out_load    = (state == S_FINISH) && stat.slot_free;
  end

endmodule

### hw/rtl/bounded_stack_with_search_core.sv
// Bounded LIFO stack of signed 32-bit words with first-match search. One request at a
// time; the search reads the stack memory (one write port, one registered read port)
// one word per cycle and compares each word in one comparator, stopping at the first
// match or after the last held word. An unknown action code is answered with status ok
// and value 0. A finished result sits in an output register; the next request is
// taken once that result has been moved into it. Push onto a full stack is dropped
// with status 1, pop from an empty stack answers status 2; fill_level is the word
// count after the action, truncated to 7 bits.
module bounded_stack_with_search_core import bss_pkg::*; #(
  parameter int DEPTH = 64
) (
  input  logic clk,
  input  logic rst,
  input  logic cmd_valid,
  output logic cmd_ready,
  input  cmd_t cmd,
  output logic res_valid,
  input  logic res_ready,
  output res_t res
);

  localparam int CW = $clog2(DEPTH + 1);
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam logic [CW-1:0] FULL_COUNT = CW'(DEPTH);

  seq_stat_t stat;
  seq_ctrl_t ctrl;

  logic [CW-1:0]      count;
  logic [CW-1:0]      idx;
  logic [CW-1:0]      pend_idx;
  logic               pend;
  logic [1:0]         act;
  logic signed [31:0] target;
  logic [1:0]         stage_status;
  logic signed [31:0] stage_value;

  logic               full;
  logic               empty;
  logic               mem_we;
  logic [AW-1:0]      raddr;
  logic [31:0]        rdata;
  logic               scan_hit;
  logic               scan_end;

  assign full  = (count == FULL_COUNT);
  assign empty = (count == '0);

  assign mem_we = ctrl.accept && (cmd.action == ACT_PUSH) && !full;
  // pop reads the top word at acceptance, the scan reads one word per cycle
  assign raddr  = ctrl.scan ? AW'(idx) : AW'(count - CW'(1));

  bss_mem #(
    .DEPTH (DEPTH),
    .AW    (AW)
  ) u_mem (
    .clk   (clk),
    .we    (mem_we),
    .waddr (AW'(count)),
    .wdata (cmd.value),
    .raddr (raddr),
    .rdata (rdata)
  );

  // only meaningful while scanning
  assign scan_hit = pend && ($signed(rdata) == target);
  assign scan_end = !pend && (idx == count);

  always_comb begin
    stat.cmd_valid = cmd_valid;
    stat.action    = cmd.action;
    stat.empty     = empty;
    stat.scan_hit  = scan_hit;
    stat.scan_end  = scan_end;
    stat.slot_free = !res_valid || res_ready;
  end

  bss_seq u_seq (
    .clk  (clk),
    .rst  (rst),
    .stat (stat),
    .ctrl (ctrl)
  );

  assign cmd_ready = ctrl.cmd_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else if (ctrl.accept) begin
      if (cmd.action == ACT_PUSH && !full) begin
        count <= count + CW'(1);
      end else if (cmd.action == ACT_POP && !empty) begin
        count <= count - CW'(1);
      end
    end
  end

  // scan: idx is the address being read, pend_idx the index of the word now on rdata
  always_ff @(posedge clk) begin
    if (rst) begin
      pend <= 1'b0;
    end else if (ctrl.accept) begin
      pend <= 1'b0;
    end else if (ctrl.scan) begin
      pend <= (idx != count);
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.accept) begin
      idx <= '0;
    end else if (ctrl.scan && idx != count) begin
      idx      <= idx + CW'(1);
      pend_idx <= idx;
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.accept) begin
      act    <= cmd.action;
      target <= cmd.value;
      unique case (cmd.action)
        ACT_PUSH: begin
          stage_status <= full ? ST_FULL : ST_OK;
          stage_value  <= '0;
        end
        ACT_POP: begin
          stage_status <= empty ? ST_EMPTY : ST_OK;
          stage_value  <= '0;
        end
        ACT_FIND: begin
          stage_status <= ST_OK;
          stage_value  <= NOT_FOUND;
        end
        default: begin
          stage_status <= ST_OK;
          stage_value  <= '0;
        end
      endcase
    end else if (ctrl.pop_capture) begin
      stage_value <= $signed(rdata);
    end else if (ctrl.scan && scan_hit) begin
      stage_value <= $signed(32'(pend_idx));
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (ctrl.out_load) begin
      res_valid <= 1'b1;
    end else if (res_ready) begin
      res_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.out_load) begin
      res.status       <= stage_status;
      res.result_value <= stage_value;
      res.fill_level   <= 7'(count);
    end
  end

  assert property (@(posedge clk) disable iff (rst) count <= FULL_COUNT)
    else $error("stack count beyond depth");

  assert property (@(posedge clk) disable iff (rst)
    ctrl.accept && cmd.action == ACT_PUSH && full |=> count == $past(count))
    else $error("dropped push changed the count");

  assert property (@(posedge clk) disable iff (rst)
    ctrl.scan && scan_hit |-> pend_idx < count)
    else $error("search hit beyond the held words");

  assert property (@(posedge clk) disable iff (rst)
    ctrl.out_load && act == ACT_POP && stage_status == ST_EMPTY |-> empty)
    else $error("empty pop reported with words held");

endmodule

### tb/sv/stack_checker.sv
`timescale 1ns / 100ps
module stack_checker import bss_pkg::*; #(
  parameter int DEPTH = 64
) (
  input  logic clk,
  input  logic rst,
  input  logic cmd_valid,
  input  logic cmd_ready,
  input  cmd_t cmd,
  input  logic res_valid,
  input  logic res_ready,
  input  res_t res,
  output int   fails,
  output int   pending
);

  logic signed [31:0] stack_words [DEPTH];
  int                 word_count;
  res_t               expected_q [$];
  int                 n_req = 0;
  int                 n_res = 0;
  int                 n_bad = 0;

  assign fails   = n_bad;
  assign pending = n_req - n_res;

  // applies one request to the shadow stack and returns the answer it should give
  function res_t apply_request(input cmd_t c);
    res_t r;
    logic hit;
    r        = '0;
    r.status = ST_OK;
    case (c.action)
      ACT_PUSH: begin
        if (word_count >= DEPTH) begin
          r.status = ST_FULL;
        end else begin
          stack_words[word_count] = c.value;
          word_count++;
        end
      end
      ACT_POP: begin
        if (word_count == 0) begin
          r.status = ST_EMPTY;
        end else begin
          word_count--;
          r.result_value = stack_words[word_count];
        end
      end
      ACT_FIND: begin
        r.result_value = NOT_FOUND;
        hit = 1'b0;
        // lowest matching index wins
        for (int i = 0; i < word_count; i++) begin
          if (!hit && stack_words[i] == c.value) begin
            hit = 1'b1;
            r.result_value = i;
          end
        end
      end
      default: begin
      end
    endcase
    r.fill_level = word_count[6:0];
    return r;
  endfunction

  always @(posedge clk) begin : watch
    res_t want;
    int   bad;
    bad = 0;
    if (rst) begin
      word_count = 0;
      expected_q.delete();
    end else begin
      // results first: a new request may be taken at the edge its predecessor leaves
      if (res_valid && res_ready) begin
        if (expected_q.size() == 0) begin
          $error("unexpected result: status %0d result_value %0d fill_level %0d",
                 res.status, res.result_value, res.fill_level);
          bad++;
        end else begin
          want = expected_q.pop_front();
          if (res.status !== want.status) begin
            $error("status: expected %0d, got %0d", want.status, res.status);
            bad++;
          end
          if (res.result_value !== want.result_value) begin
            $error("result_value: expected %0d, got %0d", want.result_value,
                   res.result_value);
            bad++;
          end
          if (res.fill_level !== want.fill_level) begin
            $error("fill_level: expected %0d, got %0d", want.fill_level, res.fill_level);
            bad++;
          end
          n_res <= n_res + 1;
        end
      end
      if (cmd_valid && cmd_ready) begin
        expected_q.push_back(apply_request(cmd));
        n_req <= n_req + 1;
      end
      if (bad != 0) begin
        n_bad <= n_bad + bad;
      end
    end
  end

endmodule

### tb/sv/tb.sv
`timescale 1ns / 100ps
module tb;
  import bss_pkg::*;

  localparam logic [1:0] ACT_UNUSED = 2'd3;
  localparam int         N_RANDOM   = 1800;
  localparam int         STALL_MAX  = 2000;

  typedef enum int {MODE_FILL, MODE_DRAIN, MODE_MIX} mode_t;

  logic clk;
  logic rst       = 1'b1;
  logic cmd_valid = 1'b0;
  logic cmd_ready;
  cmd_t cmd       = '0;
  logic res_valid;
  logic res_ready = 1'b0;
  res_t res;
  logic quiet     = 1'b0;
  int   fails;
  int   pending;
  int   hold      = 0;
  int   stall_cycles = 0;

  bounded_stack_with_search_core DUT (
    .clk       (clk),
    .rst       (rst),
    .cmd_valid (cmd_valid),
    .cmd_ready (cmd_ready),
    .cmd       (cmd),
    .res_valid (res_valid),
    .res_ready (res_ready),
    .res       (res)
  );

  stack_checker u_checker (
    .clk       (clk),
    .rst       (rst),
    .cmd_valid (cmd_valid),
    .cmd_ready (cmd_ready),
    .cmd       (cmd),
    .res_valid (res_valid),
    .res_ready (res_ready),
    .res       (res),
    .fails     (fails),
    .pending   (pending)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // result side back-pressure
  always @(posedge clk) begin
    if (rst) begin
      res_ready <= 1'b0;
      hold      <= 0;
    end else if (hold > 0) begin
      hold <= hold - 1;
    end else if (!quiet && $urandom_range(0, 3) == 0) begin
      res_ready <= 1'b0;
      hold      <= ($urandom_range(0, 9) == 0) ? $urandom_range(10, 40) : $urandom_range(0, 3);
    end else begin
      res_ready <= 1'b1;
    end
  end

  always @(posedge clk) begin
    if ((cmd_valid && cmd_ready) || (res_valid && res_ready)) begin
      stall_cycles <= 0;
    end else if (stall_cycles >= STALL_MAX) begin
      $display("end of test: mismatches");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  // holds the request until taken, returns at the accepting edge
  task send(input logic [1:0] action, input logic signed [31:0] value);
    cmd_t c;
    c.action  = action;
    c.value   = value;
    cmd_valid <= 1'b1;
    cmd       <= c;
    do @(posedge clk); while (!cmd_ready);
  endtask

  task request_gap();
    int gap;
    gap = 0;
    if (!quiet) begin
      case ($urandom_range(0, 19))
        0, 1, 2, 3, 4: gap = $urandom_range(1, 3);
        5:             gap = $urandom_range(10, 40);
        default:       gap = 0;
      endcase
    end
    if (gap > 0) begin
      cmd_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  task wait_drained();
    cmd_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
  endtask

  // small pool so that finds hit and duplicates occur
  function logic signed [31:0] pick_word();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) begin
      return $signed($urandom_range(0, 11)) - 6;
    end else if (r < 70) begin
      case ($urandom_range(0, 3))
        0:       return 32'sh7fffffff;
        1:       return 32'sh80000000;
        2:       return 32'sd0;
        default: return -32'sd1;
      endcase
    end
    return $urandom();
  endfunction

  function logic [1:0] pick_action(input mode_t m);
    int r;
    r = $urandom_range(0, 99);
    case (m)
      MODE_FILL: begin
        if (r < 85) return ACT_PUSH;
        if (r < 90) return ACT_POP;
        if (r < 98) return ACT_FIND;
      end
      MODE_DRAIN: begin
        if (r < 10) return ACT_PUSH;
        if (r < 85) return ACT_POP;
        if (r < 98) return ACT_FIND;
      end
      default: begin
        if (r < 40) return ACT_PUSH;
        if (r < 70) return ACT_POP;
        if (r < 97) return ACT_FIND;
      end
    endcase
    return ACT_UNUSED;
  endfunction

  initial begin
    int    sent;
    int    burst;
    mode_t mode;
    sent = 0;
    repeat (11) @(posedge clk);
    rst <= 1'b0;

    // empty stack cases, extremes, duplicates, unused code
    send(ACT_POP, 32'sd0);            request_gap();
    send(ACT_FIND, 32'sd0);           request_gap();
    send(ACT_PUSH, 32'sh7fffffff);    request_gap();
    send(ACT_PUSH, 32'sh80000000);    request_gap();
    send(ACT_PUSH, -32'sd1);          request_gap();
    send(ACT_PUSH, 32'sd0);           request_gap();
    send(ACT_PUSH, -32'sd1);          request_gap();
    send(ACT_FIND, -32'sd1);          request_gap();
    send(ACT_FIND, 32'sh80000000);    request_gap();
    send(ACT_FIND, 32'sh7fffffff);    request_gap();
    send(ACT_FIND, 32'sd1234);        request_gap();
    send(ACT_UNUSED, 32'sd5);         request_gap();
    send(ACT_UNUSED, -32'sd1);        request_gap();
    send(ACT_POP, 32'sh12345678);     request_gap();
    send(ACT_POP, -32'sd1);           request_gap();
    send(ACT_FIND, -32'sd1);          request_gap();
    send(ACT_POP, 32'sd0);            request_gap();
    send(ACT_POP, 32'sd0);            request_gap();
    send(ACT_POP, 32'sd0);            request_gap();
    send(ACT_POP, 32'sd0);            request_gap();
    send(ACT_PUSH, 32'sh55555555);    request_gap();
    send(ACT_PUSH, 32'shaaaaaaaa);    request_gap();
    send(ACT_FIND, 32'shaaaaaaaa);    request_gap();
    send(ACT_POP, 32'sd0);            request_gap();
    send(ACT_POP, 32'sd0);
    wait_drained();

    // bursts of one flavour; the first one fills the stack past its depth
    mode  = MODE_FILL;
    burst = 100;
    while (sent < N_RANDOM) begin
      quiet <= ($urandom_range(0, 3) == 0);
      repeat (burst) begin
        send(pick_action(mode), pick_word());
        sent++;
        request_gap();
      end
      if ($urandom_range(0, 5) == 0) begin
        wait_drained();
      end
      case ($urandom_range(0, 2))
        0:       mode = MODE_FILL;
        1:       mode = MODE_DRAIN;
        default: mode = MODE_MIX;
      endcase
      burst = $urandom_range(20, 90);
    end

    cmd_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (10) @(posedge clk);
    if (fails == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule
